[rtl/core/tks_pkg.sv]
// Shared constants and types for the key-length-value key search block.
// No dependencies; every other file of the block imports this package.
package tks_pkg;

	// Element header layout: big-endian key followed by big-endian length.
	localparam int KEY_BYTES = 2;
	localparam int LEN_BYTES = 2;
	localparam int HDR_BYTES = KEY_BYTES + LEN_BYTES;

	localparam int KEY_W = 8 * KEY_BYTES;
	localparam int LEN_W = 8 * LEN_BYTES;
	localparam int CNT_W = $clog2(HDR_BYTES + 1);

	localparam int DATA_W    = 8;
	localparam int FIELD_W   = 16;
	localparam int OUTCOME_W = 2;

	// Configuration port: two 16-bit registers, 32-bit data bus, byte addresses 0 and 4.
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_IDX_LSB = 2;

	typedef enum logic [0:0] {
		REG_SEARCH_KEY   = 1'b0,
		REG_FRAME_LENGTH = 1'b1
	} cfg_reg_t;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_FOUND    = 2'd0,
		OUT_ZERO_KEY = 2'd1,
		OUT_END      = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'b01,
		PH_SKIP   = 2'b10
	} phase_t;

	typedef struct packed {
		logic                 valid;
		outcome_t             outcome;
		logic [FIELD_W-1:0]   value_offset;
		logic [FIELD_W-1:0]   value_length;
	} tks_result_t;

	typedef struct packed {
		logic   done;
		phase_t phase;
	} tks_status_t;

endpackage

[rtl/core/tks_if.sv]
// Valid/ready channel interfaces for the byte requests and the search results.
// Depends on tks_pkg for the field widths.
interface tks_byte_if import tks_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              frame_start;
	logic [DATA_W-1:0] data_byte;

	modport source (output valid, output frame_start, output data_byte, input ready);
	modport sink   (input valid, input frame_start, input data_byte, output ready);
endinterface

interface tks_result_if import tks_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OUTCOME_W-1:0] outcome;
	logic [FIELD_W-1:0]   value_offset;
	logic [FIELD_W-1:0]   value_length;

	modport source (output valid, output outcome, output value_offset, output value_length,
		input ready);
	modport sink   (input valid, input outcome, input value_offset, input value_length,
		output ready);
endinterface

[rtl/core/tlv_key_search.sv]
// Key search over a key-length-value frame, one byte request per cycle if unstalled.
// A result is registered from the deciding byte held in the input register.
// Throughput: one byte per cycle unless a result stalls; one parse pass per byte.
// Reset (arst_n low): no frame is open, so bytes are dropped until a frame start;
// both configuration registers clear to zero and the channels come up empty.
module tlv_key_search import tks_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	tks_byte_if.sink              byte_ch,
	tks_result_if.source          result_ch
);

	logic [FIELD_W-1:0] search_key;
	logic [FIELD_W-1:0] frame_length;

	// Input register: holds one accepted byte request until the parser takes it.
	logic               valid_s1;
	logic               frame_start_s1;
	logic [DATA_W-1:0]  data_byte_s1;

	// Result register: parts the parser from the downstream handshake.
	logic               out_valid_q;
	outcome_t           outcome_q;
	logic [FIELD_W-1:0] value_offset_q;
	logic [FIELD_W-1:0] value_length_q;

	tks_result_t        step_res;
	tks_status_t        status;
	logic               advance;
	logic               in_accept;

	tks_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.search_key   (search_key),
		.frame_length (frame_length)
	);

	// The held byte is parsed when the result register is free or is being emptied,
	// so a result is never overwritten before it is taken.
	assign advance         = valid_s1 && (!out_valid_q || result_ch.ready);
	assign byte_ch.ready   = !valid_s1 || advance;
	assign in_accept       = byte_ch.valid && byte_ch.ready;

	tks_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (advance),
		.frame_start  (frame_start_s1),
		.data_byte    (data_byte_s1),
		.search_key   (search_key),
		.frame_length (frame_length),
		.result       (step_res),
		.status       (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			frame_start_s1 <= byte_ch.frame_start;
			data_byte_s1   <= byte_ch.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_res.valid;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res.valid) begin
			outcome_q      <= step_res.outcome;
			value_offset_q <= step_res.value_offset;
			value_length_q <= step_res.value_length;
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.outcome      = outcome_q;
	assign result_ch.value_offset = value_offset_q;
	assign result_ch.value_length = value_length_q;

	// A new result can only come from a byte that the parser took in the prior cycle.
	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && step_res.valid))
		else $error("result appeared without a parsed byte");

	// Every result closes the search until the next frame start.
	a_done_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_res.valid) |=> status.done)
		else $error("search still open after a result");

	// Skipping a value only happens inside an open search.
	a_skip_open: assert property (@(posedge clk) disable iff (!arst_n)
		(status.phase == PH_SKIP) |-> (!status.done && $onehot(status.phase)))
		else $error("skip phase while the search is closed");

	// Only a found key reports a nonzero value length.
	a_len_found_only: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_res.valid && step_res.outcome != OUT_FOUND)
			|-> (step_res.value_length == '0))
		else $error("nonzero length on a result other than found");

endmodule

[rtl/core/tks_cfg.sv]
// APB-style configuration registers: search key and frame length.
// Depends on tks_pkg for the register map.
module tks_cfg import tks_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [FIELD_W-1:0]    search_key,
	output logic [FIELD_W-1:0]    frame_length
);

	logic [FIELD_W-1:0] search_key_q;
	logic [FIELD_W-1:0] frame_length_q;
	cfg_reg_t           reg_sel;
	logic               wr_en;

	assign reg_sel = cfg_reg_t'(paddr[CFG_IDX_LSB]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_key_q   <= '0;
			frame_length_q <= '0;
		end else if (wr_en) begin
			case (reg_sel)
				REG_SEARCH_KEY:   search_key_q   <= pwdata[FIELD_W-1:0];
				REG_FRAME_LENGTH: frame_length_q <= pwdata[FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SEARCH_KEY:   prdata = CFG_DATA_W'(search_key_q);
			REG_FRAME_LENGTH: prdata = CFG_DATA_W'(frame_length_q);
			default:          prdata = '0;
		endcase
	end

	assign search_key   = search_key_q;
	assign frame_length = frame_length_q;

endmodule

[rtl/core/tks_parser.sv]
// Parse state of the element scan and the per-byte update logic.
// Depends on tks_pkg; consumes one byte per enabled cycle.
module tks_parser import tks_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  logic               frame_start,
	input  logic [DATA_W-1:0]  data_byte,
	input  logic [FIELD_W-1:0] search_key,
	input  logic [FIELD_W-1:0] frame_length,
	output tks_result_t        result,
	output tks_status_t        status
);

	typedef struct packed {
		logic [FIELD_W-1:0] pos;
		phase_t             phase;
		logic [CNT_W-1:0]   cnt;
		logic [KEY_W-1:0]   key;
		logic [LEN_W-1:0]   len;
		logic [FIELD_W-1:0] skip;
		logic               done;
	} state_t;

	state_t             st_q;
	state_t             nxt;
	tks_result_t        res;
	logic [FIELD_W:0]   vstart;
	logic [FIELD_W+1:0] lim;
	logic [FIELD_W:0]   remain;
	logic               fits;
	logic               match;
	logic               restart;
	logic [CNT_W-1:0]   cnt_n;
	logic [KEY_W-1:0]   key_n;
	logic [LEN_W-1:0]   len_n;

	always_comb begin
		nxt     = st_q;
		res     = '0;
		vstart  = '0;
		remain  = '0;
		fits    = 1'b0;
		match   = 1'b0;
		restart = 1'b0;
		cnt_n   = st_q.cnt;
		key_n   = st_q.key;
		len_n   = st_q.len;

		// A frame start always restarts the scan at an element boundary.
		if (frame_start) begin
			nxt.done  = 1'b0;
			nxt.pos   = '0;
			nxt.phase = PH_HEADER;
			nxt.cnt   = '0;
			nxt.key   = '0;
			nxt.len   = '0;
			nxt.skip  = '0;
			if ({2'b00, frame_length} <= (FIELD_W+2)'(HDR_BYTES)) begin
				nxt.done         = 1'b1;
				res.valid        = 1'b1;
				res.outcome      = OUT_END;
				res.value_offset = frame_length;
			end
		end

		if (!nxt.done) begin
			vstart  = {1'b0, nxt.pos} + (FIELD_W+1)'(1);
			nxt.pos = nxt.pos + FIELD_W'(1);
			if (nxt.phase == PH_SKIP) begin
				nxt.skip = nxt.skip - FIELD_W'(1);
				if (nxt.skip == '0) begin
					restart = 1'b1;
				end
			end else begin
				if (nxt.cnt < CNT_W'(KEY_BYTES)) begin
					key_n = KEY_W'({nxt.key, data_byte});
				end else begin
					len_n = LEN_W'({nxt.len, data_byte});
				end
				cnt_n   = nxt.cnt + CNT_W'(1);
				nxt.cnt = cnt_n;
				nxt.key = key_n;
				nxt.len = len_n;
				remain  = ((FIELD_W+1)'(frame_length) > vstart) ?
					(FIELD_W+1)'(frame_length) - vstart : '0;
				fits    = 33'(remain) >= 33'(len_n);
				match   = 32'(key_n) == 32'(search_key);
				if (cnt_n == CNT_W'(KEY_BYTES) && key_n == '0) begin
					nxt.done         = 1'b1;
					res.valid        = 1'b1;
					res.outcome      = OUT_ZERO_KEY;
					res.value_offset = frame_length;
				end else if (cnt_n == CNT_W'(HDR_BYTES)) begin
					if (match && fits) begin
						nxt.done         = 1'b1;
						res.valid        = 1'b1;
						res.outcome      = OUT_FOUND;
						res.value_offset = vstart[FIELD_W-1:0];
						res.value_length = FIELD_W'(len_n);
					end else if (fits && len_n != '0) begin
						nxt.phase = PH_SKIP;
						nxt.cnt   = '0;
						nxt.skip  = FIELD_W'(len_n);
					end else begin
						// Empty value or a length that overruns the frame.
						restart = 1'b1;
					end
				end
			end
		end

		lim = (FIELD_W+2)'(vstart) + (FIELD_W+2)'(HDR_BYTES);
		if (restart) begin
			nxt.phase = PH_HEADER;
			nxt.cnt   = '0;
			nxt.key   = '0;
			nxt.len   = '0;
			nxt.skip  = '0;
			if ({2'b00, frame_length} <= lim) begin
				nxt.done         = 1'b1;
				res.valid        = 1'b1;
				res.outcome      = OUT_END;
				res.value_offset = frame_length;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.pos   <= '0;
			st_q.phase <= PH_HEADER;
			st_q.cnt   <= '0;
			st_q.key   <= '0;
			st_q.len   <= '0;
			st_q.skip  <= '0;
			st_q.done  <= 1'b1;
		end else if (step_en) begin
			st_q <= nxt;
		end
	end

	assign result       = res;
	assign status.done  = st_q.done;
	assign status.phase = st_q.phase;

endmodule
